/* hdl/scdb_pkg.sv */
// shared types and constants of the soft clipper, dc blocker and gain block
package scdb_pkg;

	// default sizes
	localparam int NUM_CHANNELS_DEF = 2;
	localparam int SAMPLE_BITS_DEF  = 24;

	// filter state is signed Q4.23
	localparam int STATE_W   = 27;
	localparam int STATE_MAX = 67108863;
	localparam int STATE_MIN = -67108864;

	// configuration port
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int GAIN_RESET  = 8192;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 2'd1;

	// shaper and filter constants
	localparam int DRIVE_ONE      = 65536;
	localparam int DRIVE_ON_ABOVE = 65;
	localparam int CLAMP_LIM      = 33554432;
	localparam int K27            = 226492416;
	localparam int DC_COEF        = 16735273;

	// restoring divider: one quotient bit per step
	localparam int DIV_STEPS = 26;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE  = 4'd0,
		OP_LOAD  = 4'd1,
		OP_DRV   = 4'd2,
		OP_CLP   = 4'd3,
		OP_SQR   = 4'd4,
		OP_X2    = 4'd5,
		OP_NUM   = 4'd6,
		OP_DIVLD = 4'd7,
		OP_DIV   = 4'd8,
		OP_SHP   = 4'd9,
		OP_BYP   = 4'd10,
		OP_PASS  = 4'd11,
		OP_BLK   = 4'd12,
		OP_Y     = 4'd13,
		OP_GAIN  = 4'd14,
		OP_RES   = 4'd15
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic drive_on;
	} status_t;

endpackage

/* hdl/scdb_if.sv */
// item channel interfaces of the soft clipper block
interface scdb_in_if #(parameter int SAMPLE_BITS = scdb_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic                          channel;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source(output valid, channel, sample_in, input ready);
	modport sink(input valid, channel, sample_in, output ready);
endinterface

interface scdb_out_if #(parameter int SAMPLE_BITS = scdb_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic                          channel_out;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source(output valid, channel_out, sample_out, input ready);
	modport sink(input valid, channel_out, sample_out, output ready);
endinterface

/* hdl/scdb_dp.sv */
// datapath: config registers, shared multiplier, divider, filter state, output register
module scdb_dp #(
	parameter int NUM_CHANNELS = scdb_pkg::NUM_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = scdb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  scdb_pkg::cmd_t                     cmd,
	output scdb_pkg::status_t                  status,
	input  logic                               in_channel,
	input  logic signed [SAMPLE_BITS-1:0]      in_sample,
	output logic                               out_channel,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	input  logic                               cfg_we,
	input  logic [scdb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scdb_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int SW    = scdb_pkg::STATE_W;
	localparam int MA_W  = (SAMPLE_BITS > SW) ? SAMPLE_BITS : SW;
	localparam int MB_W  = 30;
	localparam int P_W   = MA_W + MB_W;
	localparam int CH_IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int X2_W  = 28;
	localparam int DEN_W = 31;
	localparam int D_W   = DEN_W + 1;
	localparam int N_W   = 56;
	localparam int Q_W   = scdb_pkg::DIV_STEPS;
	localparam int SUM_W = 30;

	localparam logic signed [P_W-1:0]   CL_HI   = P_W'(scdb_pkg::CLAMP_LIM);
	localparam logic signed [P_W-1:0]   CL_LO   = -P_W'(scdb_pkg::CLAMP_LIM);
	localparam logic signed [P_W-1:0]   SMAX_P  = {{(P_W-SAMPLE_BITS+1){1'b0}},
		{(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [P_W-1:0]   SMIN_P  = ~SMAX_P;
	localparam logic signed [SUM_W-1:0] ST_HI_S = SUM_W'(scdb_pkg::STATE_MAX);
	localparam logic signed [SUM_W-1:0] ST_LO_S = SUM_W'(scdb_pkg::STATE_MIN);
	localparam logic signed [MA_W-1:0]  ST_HI_A = MA_W'(scdb_pkg::STATE_MAX);
	localparam logic signed [MA_W-1:0]  ST_LO_A = MA_W'(scdb_pkg::STATE_MIN);

	// configuration registers
	logic [scdb_pkg::CFG_W-1:0] drive_q;
	logic [scdb_pkg::CFG_W-1:0] gain_q;

	// item registers
	logic                          ch_q;
	logic signed [SAMPLE_BITS-1:0] samp_q;
	logic signed [P_W-1:0]         p_q;
	logic signed [SW-1:0]          c_q;
	logic [X2_W-1:0]               x2_q;
	logic [DEN_W-1:0]              den_q;
	logic                          neg_q;
	logic [D_W-1:0]                rem_q;
	logic [Q_W-1:0]                nlo_q;
	logic signed [SW-1:0]          s_q;
	logic signed [SW-1:0]          y_q;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic                          out_ch_q;
	logic signed [SAMPLE_BITS-1:0] out_samp_q;

	// per-channel filter state
	logic signed [SW-1:0] sp_q [NUM_CHANNELS];
	logic signed [SW-1:0] yp_q [NUM_CHANNELS];

	logic [CH_IW-1:0]        idx;
	logic [17:0]             fac;
	logic [28:0]             nfac;
	logic signed [MA_W-1:0]  ma;
	logic signed [MB_W-1:0]  mb;
	logic                    mul_en;
	logic signed [P_W-1:0]   rnd_clp;
	logic signed [P_W-1:0]   t_clp;
	logic signed [SW-1:0]    c_d;
	logic [P_W-1:0]          rnd_x2;
	logic signed [P_W-1:0]   mag;
	logic [N_W-1:0]          n_full;
	logic [D_W-1:0]          dvs;
	logic [D_W:0]            trial;
	logic                    ge;
	logic signed [MA_W-1:0]  sx;
	logic signed [SW-1:0]    s_byp;
	logic signed [P_W-1:0]   rnd_blk;
	logic signed [SUM_W-1:0] sum;
	logic signed [SW-1:0]    y_d;
	logic signed [P_W-1:0]   rnd_out;
	logic signed [P_W-1:0]   t_out;
	logic signed [SAMPLE_BITS-1:0] res_d;

	assign idx = CH_IW'(ch_q);

	// status toward the controller
	assign status.active   = ({31'd0, ch_q} < 32'(NUM_CHANNELS));
	assign status.drive_on = (drive_q > scdb_pkg::CFG_W'(scdb_pkg::DRIVE_ON_ABOVE));

	// drive factor 1 + 3*drive in Q16, and numerator factor 27 + x^2
	assign fac  = 18'(scdb_pkg::DRIVE_ONE) + 18'({drive_q, 1'b0}) + 18'(drive_q);
	assign nfac = 29'(scdb_pkg::K27) + 29'(x2_q);

	// shared multiplier operand select
	always_comb begin
		ma     = '0;
		mb     = '0;
		mul_en = 1'b0;
		unique case (cmd.op)
			scdb_pkg::OP_DRV: begin
				ma     = MA_W'(samp_q);
				mb     = MB_W'(fac);
				mul_en = 1'b1;
			end
			scdb_pkg::OP_SQR: begin
				ma     = MA_W'(c_q);
				mb     = MB_W'(c_q);
				mul_en = 1'b1;
			end
			scdb_pkg::OP_NUM: begin
				ma     = MA_W'(c_q);
				mb     = MB_W'(nfac);
				mul_en = 1'b1;
			end
			scdb_pkg::OP_BLK: begin
				ma     = MA_W'(yp_q[idx]);
				mb     = MB_W'(scdb_pkg::DC_COEF);
				mul_en = 1'b1;
			end
			scdb_pkg::OP_GAIN: begin
				ma     = MA_W'(y_q);
				mb     = MB_W'({1'b0, gain_q});
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// round and clamp of the driven sample
	always_comb begin
		rnd_clp = p_q + P_W'(32768);
		t_clp   = rnd_clp >>> 16;
		if (t_clp > CL_HI) begin
			c_d = SW'(CL_HI);
		end else if (t_clp < CL_LO) begin
			c_d = SW'(CL_LO);
		end else begin
			c_d = SW'(t_clp);
		end
	end

	// x^2 back to Q23, p_q is a square here
	assign rnd_x2 = p_q + P_W'(4194304);

	// divider setup: |num|*2 + den over 2*den
	assign mag    = p_q[P_W-1] ? -p_q : p_q;
	assign n_full = {mag[N_W-2:0], 1'b0} + N_W'(den_q);
	assign dvs    = {den_q, 1'b0};

	// one restoring step
	assign trial = {rem_q, nlo_q[Q_W-1]};
	assign ge    = (trial >= {1'b0, dvs});

	// saturation of the unshaped sample to the state range
	always_comb begin
		sx = MA_W'(samp_q);
		if (sx > ST_HI_A) begin
			s_byp = SW'(ST_HI_A);
		end else if (sx < ST_LO_A) begin
			s_byp = SW'(ST_LO_A);
		end else begin
			s_byp = SW'(sx);
		end
	end

	// dc blocker update
	always_comb begin
		rnd_blk = p_q + P_W'(8388608);
		sum     = SUM_W'(s_q) - SUM_W'(sp_q[idx]) + SUM_W'(rnd_blk >>> 24);
		if (sum > ST_HI_S) begin
			y_d = SW'(ST_HI_S);
		end else if (sum < ST_LO_S) begin
			y_d = SW'(ST_LO_S);
		end else begin
			y_d = SW'(sum);
		end
	end

	// gain rounding and output saturation
	always_comb begin
		rnd_out = p_q + P_W'(4096);
		t_out   = rnd_out >>> 13;
		if (t_out > SMAX_P) begin
			res_d = SAMPLE_BITS'(SMAX_P);
		end else if (t_out < SMIN_P) begin
			res_d = SAMPLE_BITS'(SMIN_P);
		end else begin
			res_d = SAMPLE_BITS'(t_out);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= '0;
			gain_q  <= scdb_pkg::CFG_W'(scdb_pkg::GAIN_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				scdb_pkg::REG_DRIVE:       drive_q <= cfg_wdata;
				scdb_pkg::REG_OUTPUT_GAIN: gain_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// filter state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				sp_q[i] <= '0;
				yp_q[i] <= '0;
			end
		end else if (cmd.op == scdb_pkg::OP_Y) begin
			sp_q[idx] <= s_q;
			yp_q[idx] <= y_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			p_q <= ma * mb;
		end
		unique case (cmd.op)
			scdb_pkg::OP_LOAD: begin
				ch_q   <= in_channel;
				samp_q <= in_sample;
			end
			scdb_pkg::OP_CLP: c_q <= c_d;
			scdb_pkg::OP_X2:  x2_q <= rnd_x2[23+X2_W-1:23];
			scdb_pkg::OP_NUM: den_q <= DEN_W'(scdb_pkg::K27) + DEN_W'({x2_q, 3'b000})
				+ DEN_W'(x2_q);
			scdb_pkg::OP_DIVLD: begin
				neg_q <= p_q[P_W-1];
				rem_q <= D_W'(n_full[N_W-1:Q_W]);
				nlo_q <= n_full[Q_W-1:0];
			end
			scdb_pkg::OP_DIV: begin
				rem_q <= ge ? D_W'(trial - {1'b0, dvs}) : trial[D_W-1:0];
				nlo_q <= {nlo_q[Q_W-2:0], ge};
			end
			scdb_pkg::OP_SHP:  s_q <= neg_q ? -SW'(nlo_q) : SW'(nlo_q);
			scdb_pkg::OP_BYP:  s_q <= s_byp;
			scdb_pkg::OP_PASS: res_q <= samp_q;
			scdb_pkg::OP_Y:    y_q <= y_d;
			scdb_pkg::OP_RES:  res_q <= res_d;
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			out_ch_q   <= ch_q;
			out_samp_q <= res_q;
		end
	end

	assign out_channel = out_ch_q;
	assign out_sample  = out_samp_q;

endmodule

/* hdl/scdb_ctrl.sv */
// controller: sequences one item through the datapath and owns the handshakes
module scdb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  scdb_pkg::status_t status,
	output scdb_pkg::cmd_t    cmd
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_DRV   = 16'h0002,
		S_CLP   = 16'h0004,
		S_SQR   = 16'h0008,
		S_X2    = 16'h0010,
		S_NUM   = 16'h0020,
		S_DIVLD = 16'h0040,
		S_DIV   = 16'h0080,
		S_SHP   = 16'h0100,
		S_BYP   = 16'h0200,
		S_PASS  = 16'h0400,
		S_BLK   = 16'h0800,
		S_Y     = 16'h1000,
		S_GAIN  = 16'h2000,
		S_RES   = 16'h4000,
		S_DONE  = 16'h8000
	} state_t;

	state_t                          state_q;
	state_t                          state_d;
	logic [scdb_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                            out_valid_q;
	logic                            accept;
	logic                            slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state and datapath command
	always_comb begin
		state_d      = state_q;
		cmd.op       = scdb_pkg::OP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op  = scdb_pkg::OP_LOAD;
					state_d = S_DRV;
				end
			end
			S_DRV: begin
				cmd.op = scdb_pkg::OP_DRV;
				if (!status.active) begin
					state_d = S_PASS;
				end else if (status.drive_on) begin
					state_d = S_CLP;
				end else begin
					state_d = S_BYP;
				end
			end
			S_CLP: begin
				cmd.op  = scdb_pkg::OP_CLP;
				state_d = S_SQR;
			end
			S_SQR: begin
				cmd.op  = scdb_pkg::OP_SQR;
				state_d = S_X2;
			end
			S_X2: begin
				cmd.op  = scdb_pkg::OP_X2;
				state_d = S_NUM;
			end
			S_NUM: begin
				cmd.op  = scdb_pkg::OP_NUM;
				state_d = S_DIVLD;
			end
			S_DIVLD: begin
				cmd.op  = scdb_pkg::OP_DIVLD;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = scdb_pkg::OP_DIV;
				if (cnt_q == scdb_pkg::DIV_CNT_W'(scdb_pkg::DIV_STEPS - 1)) begin
					state_d = S_SHP;
				end
			end
			S_SHP: begin
				cmd.op  = scdb_pkg::OP_SHP;
				state_d = S_BLK;
			end
			S_BYP: begin
				cmd.op  = scdb_pkg::OP_BYP;
				state_d = S_BLK;
			end
			S_PASS: begin
				cmd.op  = scdb_pkg::OP_PASS;
				state_d = S_DONE;
			end
			S_BLK: begin
				cmd.op  = scdb_pkg::OP_BLK;
				state_d = S_Y;
			end
			S_Y: begin
				cmd.op  = scdb_pkg::OP_Y;
				state_d = S_GAIN;
			end
			S_GAIN: begin
				cmd.op  = scdb_pkg::OP_GAIN;
				state_d = S_RES;
			end
			S_RES: begin
				cmd.op  = scdb_pkg::OP_RES;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, divider step count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + scdb_pkg::DIV_CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// an accepted item always starts at the drive multiply
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DRV)
		else $error("accepted item did not start the sequence");

	// a finished result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// the divider runs exactly its step count
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == scdb_pkg::DIV_CNT_W'(scdb_pkg::DIV_STEPS - 1))
		|=> state_q == S_SHP)
		else $error("divider left at the wrong step");

	// a new result appears only from the final state
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("output valid raised outside the final state");

endmodule

/* hdl/soft_clip_dc_block_gain_core.sv */
// top level of the soft clipper, dc blocker and output gain block
// Each item is one audio sample with its channel number. A new item is
// accepted only once the previous one has run through its sequence. With
// drive above 65 the restoring divider of the Pade soft clipper produces
// one quotient bit per cycle, and the single shared multiplier takes five
// products in turn. With drive at 65 or below the shaper is skipped; a
// channel number outside the filter bank passes the sample through. A
// result sits in an output register, so the next item is accepted while
// the previous result still waits to be taken.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; index
// 0 is drive (Q0.16), index 1 is output gain (Q3.13), other indexes are
// ignored.
module soft_clip_dc_block_gain_core #(
	parameter int NUM_CHANNELS = scdb_pkg::NUM_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = scdb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	scdb_in_if.sink                        in_ch,
	scdb_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [scdb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [scdb_pkg::CFG_W-1:0]     cfg_wdata
);

	scdb_pkg::cmd_t    cmd;
	scdb_pkg::status_t status;

	// sequencer
	scdb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and state
	scdb_dp #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_channel  (in_ch.channel),
		.in_sample   (in_ch.sample_in),
		.out_channel (out_ch.channel_out),
		.out_sample  (out_ch.sample_out),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

endmodule

/* test/soft_clip_dc_block_gain_core_tb.sv */
// self-checking testbench of the soft clipper, dc blocker and output gain block
module soft_clip_dc_block_gain_core_tb;

	localparam int SW             = scdb_pkg::SAMPLE_BITS_DEF;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int END_CYCLES     = 64;
	localparam int MAX_REPORTS    = 100;

	// arithmetic constants of the signal chain
	localparam longint DRIVE_THRESHOLD = 65;
	localparam longint UNITY_GAIN      = 8192;
	localparam longint DRIVE_UNIT      = 65536;
	localparam longint SHAPE_LIMIT     = 64'sd4 << 23;
	localparam longint PADE_27         = 64'sd27 << 23;
	localparam longint BLOCK_COEF      = 16735273;
	localparam longint ACC_MAX         = 67108863;
	localparam longint ACC_MIN         = -67108864;
	localparam longint OUT_MAX         = (64'sd1 << (SW - 1)) - 1;
	localparam longint OUT_MIN         = -(64'sd1 << (SW - 1));

	// register indexes the block ignores
	localparam logic [scdb_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [scdb_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam logic signed [SW-1:0] FULL_POS = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] FULL_NEG = {1'b1, {(SW - 1){1'b0}}};

	typedef struct packed {
		logic                 channel;
		logic signed [SW-1:0] sample;
	} sample_item_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [scdb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [scdb_pkg::CFG_W-1:0]     cfg_wdata;

	scdb_in_if  #(.SAMPLE_BITS(SW)) in_if ();
	scdb_out_if #(.SAMPLE_BITS(SW)) out_if ();

	soft_clip_dc_block_gain_core #(
		.NUM_CHANNELS(scdb_pkg::NUM_CHANNELS_DEF),
		.SAMPLE_BITS(SW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_if),
		.out_ch(out_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// mirror of the registers and the per-channel filter state
	logic [scdb_pkg::CFG_W-1:0] drive_r;
	logic [scdb_pkg::CFG_W-1:0] gain_r;
	longint                     prev_shaped [2];
	longint                     prev_blocked [2];
	longint                     walk_level [2];

	sample_item_t expected_out [$];

	int  errors          = 0;
	int  reports         = 0;
	int  items_sent      = 0;
	int  results_checked = 0;
	int  settings_used   = 0;
	int  holds_done      = 0;
	int  quiet_cycles    = 0;
	bit  idle_on         = 1'b1;
	bit  hold_req        = 1'b0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// pade tanh soft clip of the driven sample, rounded half away from zero
	function automatic longint pade_shape(input longint s);
		longint f;
		longint c;
		longint x2;
		longint num;
		longint den;
		longint mag;
		longint q;
		f   = DRIVE_UNIT + 3 * longint'(drive_r);
		c   = clamp_to((s * f + 32768) >>> 16, -SHAPE_LIMIT, SHAPE_LIMIT);
		x2  = (c * c + (64'sd1 << 22)) >>> 23;
		num = c * (PADE_27 + x2);
		den = PADE_27 + 9 * x2;
		mag = (num < 0) ? -num : num;
		q   = (2 * mag + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	// expected output of one item; advances the channel's filter state
	function automatic sample_item_t process_sample(input logic ch,
			input logic signed [SW-1:0] smp);
		sample_item_t res;
		longint       s;
		longint       y;
		longint       o;
		s = longint'(smp);
		if (longint'(drive_r) > DRIVE_THRESHOLD)
			s = pade_shape(s);
		s = clamp_to(s, ACC_MIN, ACC_MAX);
		y = s - prev_shaped[ch] + ((prev_blocked[ch] * BLOCK_COEF + (64'sd1 << 23)) >>> 24);
		y = clamp_to(y, ACC_MIN, ACC_MAX);
		prev_shaped[ch]  = s;
		prev_blocked[ch] = y;
		o = clamp_to((y * longint'(gain_r) + 4096) >>> 13, OUT_MIN, OUT_MAX);
		res.channel = ch;
		res.sample  = o[SW-1:0];
		return res;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// random sample: full range, extremes, near zero or a slow walk per channel
	function automatic logic signed [SW-1:0] random_sample(input logic ch);
		logic signed [SW-1:0] v;
		int                   r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			v = SW'($urandom);
		end else if (r < 50) begin
			case ($urandom_range(0, 3))
				0: v = FULL_POS;
				1: v = FULL_NEG;
				2: v = '0;
				default: v = '1;
			endcase
		end else if (r < 65) begin
			v = SW'(int'($urandom_range(0, 2047)) - 1024);
		end else begin
			walk_level[ch] = clamp_to(walk_level[ch] + longint'($urandom_range(0, 1 << 18))
				- (64'sd1 << 17), longint'(FULL_NEG), longint'(FULL_POS));
			v = walk_level[ch][SW-1:0];
		end
		return v;
	endfunction

	// offer one item until accepted, then maybe idle
	task automatic send_item(input logic ch, input logic signed [SW-1:0] smp);
		int gap;
		in_if.valid     <= 1'b1;
		in_if.channel   <= ch;
		in_if.sample_in <= smp;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		expected_out.push_back(process_sample(ch, smp));
		items_sent++;
		gap = idle_len();
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait until every expected result has come
	task automatic drain();
		in_if.valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
	endtask

	// one register write; the enable stays high for a following write
	task automatic cfg_write(input logic [scdb_pkg::CFG_IDX_W-1:0] idx,
			input logic [scdb_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == scdb_pkg::REG_DRIVE)
			drive_r = val;
		else if (idx == scdb_pkg::REG_OUTPUT_GAIN)
			gain_r = val;
	endtask

	task automatic set_regs(input logic [scdb_pkg::CFG_W-1:0] drv,
			input logic [scdb_pkg::CFG_W-1:0] gain);
		drain();
		cfg_write(scdb_pkg::REG_DRIVE, drv);
		cfg_write(scdb_pkg::REG_OUTPUT_GAIN, gain);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// reset values: no shaping, unity gain
	task automatic test_reset_defaults();
		send_item(1'b0, FULL_POS);
		send_item(1'b0, FULL_NEG);
		send_item(1'b1, '0);
		send_item(1'b1, '1);
		send_item(1'b0, SW'(1));
		send_item(1'b1, FULL_POS);
	endtask

	// writes to unused indexes change nothing
	task automatic test_spare_indexes();
		drain();
		cfg_write(REG_SPARE_A, 16'hFFFF);
		cfg_write(REG_SPARE_B, 16'h5A5A);
		cfg_we <= 1'b0;
		send_item(1'b0, FULL_NEG);
		send_item(1'b1, FULL_POS);
	endtask

	// shaper bypassed at the threshold, enabled just above it
	task automatic test_drive_threshold();
		set_regs(16'(DRIVE_THRESHOLD), 16'(UNITY_GAIN));
		send_item(1'b0, 24'sh400000);
		set_regs(16'(DRIVE_THRESHOLD + 1), 16'(UNITY_GAIN));
		send_item(1'b0, 24'sh400000);
		send_item(1'b1, FULL_NEG);
	endtask

	// full drive clamps at four, full gain saturates the output
	task automatic test_full_drive_and_gain();
		set_regs(16'hFFFF, 16'hFFFF);
		send_item(1'b0, FULL_POS);
		send_item(1'b0, FULL_NEG);
		send_item(1'b1, FULL_POS);
		send_item(1'b1, '0);
		send_item(1'b0, '1);
	endtask

	// zero gain silences the output
	task automatic test_zero_gain();
		set_regs(16'd30000, 16'd0);
		send_item(1'b0, FULL_POS);
		send_item(1'b1, FULL_NEG);
	endtask

	// full-scale square wave pushes the blocker toward its limits
	task automatic test_blocker_swing();
		set_regs(16'd0, 16'hFFFF);
		for (int i = 0; i < 6; i++)
			send_item(1'b1, (i % 2 == 0) ? FULL_POS : FULL_NEG);
	endtask

	// receiver holds off long while items keep coming
	task automatic test_output_hold();
		logic ch;
		set_regs(16'd20000, 16'(UNITY_GAIN));
		idle_on  = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 16; i++) begin
			ch = 1'($urandom_range(0, 1));
			send_item(ch, random_sample(ch));
		end
		drain();
		idle_on = 1'b1;
	endtask

	// random items over several register settings
	task automatic test_random_stream();
		logic [scdb_pkg::CFG_W-1:0] drv;
		logic [scdb_pkg::CFG_W-1:0] gain;
		logic                       ch;
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin drv = 16'hFFFF; gain = 16'hFFFF; end
				1: begin drv = 16'd0; gain = 16'd0; end
				2: begin drv = 16'(DRIVE_THRESHOLD + 1); gain = 16'(UNITY_GAIN); end
				3: begin drv = 16'(DRIVE_THRESHOLD); gain = 16'($urandom); end
				default: begin
					if ($urandom_range(0, 9) < 7)
						drv = 16'($urandom_range(DRIVE_THRESHOLD + 1, 65535));
					else
						drv = 16'($urandom_range(0, DRIVE_THRESHOLD));
					gain = 16'($urandom);
				end
			endcase
			set_regs(drv, gain);
			for (int i = 0; i < 110; i++) begin
				if (i % 40 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				if (i == 60 && p % 3 == 0)
					drain();
				ch = 1'($urandom_range(0, 1));
				send_item(ch, random_sample(ch));
			end
		end
		idle_on = 1'b1;
	endtask

	// receiver: random stalls and the long hold-off on request
	initial begin
		int n;
		out_if.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else begin
				n = idle_len();
				if (n > 0) begin
					out_if.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			out_if.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		sample_item_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_out.size() == 0) begin
				errors++;
				if (reports++ < MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual ch %0d sample %0d",
						$time, out_if.channel_out, out_if.sample_out);
			end else begin
				want = expected_out.pop_front();
				results_checked++;
				if (want.channel !== out_if.channel_out) begin
					errors++;
					if (reports++ < MAX_REPORTS)
						$display("%0t: channel_out mismatch, expected %0d, actual %0d",
							$time, want.channel, out_if.channel_out);
				end
				if (want.sample !== out_if.sample_out) begin
					errors++;
					if (reports++ < MAX_REPORTS)
						$display("%0t: sample_out mismatch, expected %0d, actual %0d",
							$time, want.sample, out_if.sample_out);
				end
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d results outstanding",
					$time, WATCHDOG_LIMIT, expected_out.size());
				$display("soft_clip_dc_block_gain_core_tb failed");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		arst_n          <= 1'b0;
		in_if.valid     <= 1'b0;
		in_if.channel   <= 1'b0;
		in_if.sample_in <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= scdb_pkg::REG_DRIVE;
		cfg_wdata       <= '0;
		drive_r = '0;
		gain_r  = 16'(UNITY_GAIN);
		for (int c = 0; c < 2; c++) begin
			prev_shaped[c]  = 0;
			prev_blocked[c] = 0;
			walk_level[c]   = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_spare_indexes();
		test_drive_threshold();
		test_full_drive_and_gain();
		test_zero_gain();
		test_blocker_swing();
		test_output_hold();
		test_random_stream();

		drain();
		repeat (END_CYCLES) @(posedge clk);
		if (expected_out.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_out.size());
			errors += expected_out.size();
		end
		$display("run covered %0d items on both channels over %0d register settings,",
			items_sent, settings_used + 1);
		$display("bypass and soft-clip paths, %0d long output hold-offs, %0d results compared",
			holds_done, results_checked);
		if (errors == 0)
			$display("soft_clip_dc_block_gain_core_tb passed");
		else
			$display("soft_clip_dc_block_gain_core_tb failed");
		$finish;
	end

endmodule
